// ----- rtl/core/gli_pkg.sv -----
// Shared types and constants for the gamma lookup and PWM duty block.
package gli_pkg;

  // Port field widths.
  localparam int CH_W    = 2;
  localparam int LEVEL_W = 12;
  localparam int INDEX_W = 9;
  localparam int VALUE_W = 16;
  localparam int WRAP_W  = 16;
  localparam int MASK_W  = 4;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [WRAP_W-1:0] WRAP_RESET = 16'd4095;
  localparam logic [MASK_W-1:0] MASK_RESET = 4'd7;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_CONVERT = 1'b1
  } kind_t;

  typedef enum logic {
    REG_WRAP = 1'b0,
    REG_MASK = 1'b1
  } cfg_reg_t;

  // Control that travels with a convert item from the table read onward.
  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] channel;
  } pipe_ctl_t;

endpackage

// ----- rtl/core/gli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/gli_table.sv -----
// Gamma table split into even and odd banks so two neighbors are read per cycle.
module gli_table #(
  parameter int INDEX_BITS = 9,
  parameter int DUTY_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [INDEX_BITS-1:0] waddr,
  input  logic [DUTY_BITS-1:0]  wdata,
  input  logic                  re,
  input  logic [INDEX_BITS-1:0] ridx,
  output logic [DUTY_BITS-1:0]  a,
  output logic [DUTY_BITS-1:0]  b
);

  localparam int HALF_W     = INDEX_BITS - 1;
  localparam int BANK_DEPTH = 1 << HALF_W;

  logic [HALF_W-1:0]    rhalf;
  logic                 rodd;
  logic [HALF_W-1:0]    even_raddr;
  logic [DUTY_BITS-1:0] even_rdata;
  logic [DUTY_BITS-1:0] odd_rdata;
  logic                 even_we;
  logic                 odd_we;
  logic                 odd_first;

  assign rhalf = ridx[INDEX_BITS-1:1];
  assign rodd  = ridx[0];

  // For an odd index the upper neighbor sits in the next row of the even bank.
  assign even_raddr = rodd ? rhalf + HALF_W'(1) : rhalf;

  assign even_we = we && !waddr[0];
  assign odd_we  = we && waddr[0];

  gli_ram #(
    .WIDTH (DUTY_BITS),
    .DEPTH (BANK_DEPTH)
  ) u_even (
    .clk   (clk),
    .we    (even_we),
    .waddr (waddr[INDEX_BITS-1:1]),
    .wdata (wdata),
    .re    (re),
    .raddr (even_raddr),
    .rdata (even_rdata)
  );

  gli_ram #(
    .WIDTH (DUTY_BITS),
    .DEPTH (BANK_DEPTH)
  ) u_odd (
    .clk   (clk),
    .we    (odd_we),
    .waddr (waddr[INDEX_BITS-1:1]),
    .wdata (wdata),
    .re    (re),
    .raddr (rhalf),
    .rdata (odd_rdata)
  );

  always_ff @(posedge clk) begin
    if (re) begin
      odd_first <= rodd;
    end
  end

  assign a = odd_first ? odd_rdata : even_rdata;
  assign b = odd_first ? even_rdata : odd_rdata;

endmodule

// ----- rtl/core/gli_interp.sv -----
// Product, interpolation and polarity stages with the output register.
module gli_interp #(
  parameter int DUTY_BITS = 16,
  parameter int FRAC_BITS = 3,
  parameter int FRAC_W    = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gli_pkg::pipe_ctl_t            s1,
  input  logic [FRAC_W-1:0]             frac,
  input  logic [DUTY_BITS-1:0]          a,
  input  logic [DUTY_BITS-1:0]          b,
  input  logic [gli_pkg::WRAP_W-1:0]    wrap_value,
  input  logic [gli_pkg::MASK_W-1:0]    active_low_mask,
  output logic                          s1_ready,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [gli_pkg::CH_W-1:0]      out_channel,
  output logic [DUTY_BITS-1:0]          duty,
  output logic [gli_pkg::WRAP_W-1:0]    compare_level
);

  localparam int PROD_W = DUTY_BITS + FRAC_W;
  localparam logic [PROD_W:0] ROUND_UP = (PROD_W + 1)'((1 << FRAC_BITS) - 1);

  // Product stage.
  logic                     v2;
  logic [gli_pkg::CH_W-1:0] ch2;
  logic [DUTY_BITS-1:0]     a2;
  logic [PROD_W-1:0]        prod2;
  logic                     neg2;
  logic                     en2;
  logic                     en3;

  logic                     falling;
  logic [DUTY_BITS-1:0]     diff;
  logic [PROD_W:0]          step_sum;
  logic [DUTY_BITS-1:0]     step;
  logic [DUTY_BITS-1:0]     duty_next;
  logic [gli_pkg::WRAP_W-1:0] duty_ext;
  logic [gli_pkg::WRAP_W-1:0] compare_next;

  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign s1_ready = en2;

  assign falling = b < a;
  assign diff    = falling ? a - b : b - a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ch2   <= s1.channel;
      a2    <= a;
      neg2  <= falling;
      prod2 <= PROD_W'(diff) * PROD_W'(frac);
    end
  end

  // A falling step rounds toward minus infinity, so its magnitude rounds up.
  always_comb begin
    step_sum     = {1'b0, prod2} + (neg2 ? ROUND_UP : '0);
    step         = DUTY_BITS'(step_sum >> FRAC_BITS);
    duty_next    = neg2 ? a2 - step : a2 + step;
    duty_ext     = gli_pkg::WRAP_W'(duty_next);
    compare_next = duty_ext;
    if (active_low_mask[ch2]) begin
      compare_next = (duty_ext > wrap_value) ? '0 : wrap_value - duty_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_channel   <= ch2;
      duty          <= duty_next;
      compare_level <= compare_next;
    end
  end

endmodule

// ----- rtl/core/gamma_lut_interp_pwm_duty_top.sv -----
// Top level: stream ports, configuration registers, table read stage and result pipeline.
// Pipeline: after its input transfer an item passes the table read, the product stage and
// interpolation and polarity into the output register. Throughput: one item per cycle
// from separate even and odd table banks unless the output stalls; loads give no result.
// Reset clears the valid bits and sets wrap_value to 4095 and active_low_mask to 7;
// table contents are undefined until loaded and no clearing pass is made.
module gamma_lut_interp_pwm_duty_top #(
  parameter int INDEX_BITS = 9,
  parameter int LEVEL_BITS = 12,
  parameter int DUTY_BITS  = 16,
  parameter int CHANNELS   = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // entry_index, entry_value, channel, light_level, zero pad
  input  logic [gli_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_channel, duty, compare_level, zero pad
  output logic [gli_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [gli_pkg::WRAP_W-1:0]        cfg_data
);

  localparam int FRAC_BITS = (LEVEL_BITS > INDEX_BITS) ? LEVEL_BITS - INDEX_BITS : 0;
  localparam int FRAC_W    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
  localparam logic [INDEX_BITS-1:0] TOP_INDEX = '1;

  logic [gli_pkg::WRAP_W-1:0] wrap_value;
  logic [gli_pkg::MASK_W-1:0] active_low_mask;

  logic [gli_pkg::INDEX_W-1:0] entry_index;
  logic [gli_pkg::VALUE_W-1:0] entry_value;
  logic [gli_pkg::CH_W-1:0]    channel;
  logic [gli_pkg::LEVEL_W-1:0] light_level;
  gli_pkg::kind_t              kind;

  logic                  in_xfer;
  logic                  en1;
  logic                  s1_ready;
  logic                  load_we;
  logic                  convert_ok;
  logic [LEVEL_BITS-1:0] level;
  logic [INDEX_BITS-1:0] idx;
  logic [FRAC_W-1:0]     frac_next;

  gli_pkg::pipe_ctl_t    s1;
  logic [FRAC_W-1:0]     frac1;
  logic [DUTY_BITS-1:0]  a1;
  logic [DUTY_BITS-1:0]  b1;

  logic [gli_pkg::CH_W-1:0]   out_channel;
  logic [DUTY_BITS-1:0]       duty;
  logic [gli_pkg::WRAP_W-1:0] compare_level;

  assign entry_index = s_axis_tdata[8:0];
  assign entry_value = s_axis_tdata[24:9];
  assign channel     = s_axis_tdata[26:25];
  assign light_level = s_axis_tdata[38:27];
  assign kind        = gli_pkg::kind_t'(s_axis_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_value      <= gli_pkg::WRAP_RESET;
      active_low_mask <= gli_pkg::MASK_RESET;
    end else if (cfg_we) begin
      case (gli_pkg::cfg_reg_t'(cfg_index))
        gli_pkg::REG_WRAP: wrap_value <= cfg_data;
        gli_pkg::REG_MASK: active_low_mask <= cfg_data[gli_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign en1           = !s1.valid || s1_ready;
  assign s_axis_tready = en1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Loads write at transfer time; any later convert reads after this edge.
  assign load_we    = in_xfer && (kind == gli_pkg::KIND_LOAD);
  assign convert_ok = in_xfer && (kind == gli_pkg::KIND_CONVERT)
                      && (int'(channel) < CHANNELS);

  assign level = LEVEL_BITS'(light_level);
  assign idx   = INDEX_BITS'(level >> FRAC_BITS);

  // At the last entry the fraction is dropped, which returns that entry alone.
  always_comb begin
    frac_next = '0;
    if (FRAC_BITS > 0 && idx != TOP_INDEX) begin
      frac_next = FRAC_W'(level);
    end
  end

  gli_table #(
    .INDEX_BITS (INDEX_BITS),
    .DUTY_BITS  (DUTY_BITS)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (INDEX_BITS'(entry_index)),
    .wdata (DUTY_BITS'(entry_value)),
    .re    (en1),
    .ridx  (idx),
    .a     (a1),
    .b     (b1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en1) begin
      s1.valid <= convert_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1.channel <= channel;
      frac1      <= frac_next;
    end
  end

  gli_interp #(
    .DUTY_BITS (DUTY_BITS),
    .FRAC_BITS (FRAC_BITS),
    .FRAC_W    (FRAC_W)
  ) u_interp (
    .clk             (clk),
    .rst             (rst),
    .s1              (s1),
    .frac            (frac1),
    .a               (a1),
    .b               (b1),
    .wrap_value      (wrap_value),
    .active_low_mask (active_low_mask),
    .s1_ready        (s1_ready),
    .out_ready       (m_axis_tready),
    .out_valid       (m_axis_tvalid),
    .out_channel     (out_channel),
    .duty            (duty),
    .compare_level   (compare_level)
  );

  assign m_axis_tdata = {6'b0, compare_level, gli_pkg::VALUE_W'(duty), out_channel};

`ifndef SYNTH
  // A load transfer never places an item in the read stage.
  assert property (@(posedge clk) disable iff (rst)
    load_we |=> !s1.valid)
    else $error("load item entered the read stage");

  // A convert for an existing channel always enters the read stage.
  assert property (@(posedge clk) disable iff (rst)
    convert_ok |=> s1.valid)
    else $error("convert item lost at the read stage");

  // A blocked read stage keeps its item and its fraction.
  assert property (@(posedge clk) disable iff (rst)
    s1.valid && !en1 |=> s1.valid && $stable(s1.channel) && $stable(frac1))
    else $error("read stage changed while blocked");

  // An active-low result never exceeds the wrap value.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && active_low_mask[out_channel] |-> compare_level <= wrap_value)
    else $error("inverted compare level above wrap");

  // An active-high result passes the duty through unchanged.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !active_low_mask[out_channel]
      |-> compare_level == gli_pkg::WRAP_W'(duty))
    else $error("active-high compare level differs from duty");
`endif

endmodule
